@@ hdl/shpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// shpcd_pkg
// Types, constants and the byte-wide crc-32 update shared by the deframer.
// ----------------------------------------------------------------------------
package shpcd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HdrShW   = 40;
  localparam int unsigned HdrCntW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned OutDataW = 80;

  localparam logic [WordW-1:0]   SyncWord       = 32'h5741_534D;  // "WASM"
  localparam logic [HdrCntW-1:0] HdrBytes       = 3'd6;
  localparam logic [HdrCntW-1:0] HdrKeptBytes   = 3'd5;
  localparam logic [WordW-1:0]   CrcPoly        = 32'hEDB8_8320;
  localparam logic [WordW-1:0]   CrcInit        = 32'hFFFF_FFFF;
  localparam logic [ByteW-1:0]   StatusCmdRst   = 8'd0;
  localparam logic [WordW-1:0]   MaxPayloadRst  = 32'd65536;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_STATUS_CMD  = 2'd0,
    CFG_MAX_PAYLOAD = 2'd1
  } cfg_idx_e;

  typedef enum logic [StatusW-1:0] {
    ST_IDLE      = 3'd0,
    ST_RECEIVING = 3'd1,
    ST_STATUS    = 3'd2,
    ST_SIZE_ERR  = 3'd3,
    ST_CRC_ERR   = 3'd4,
    ST_COMPLETE  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_TRAILER = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [WordW-1:0] frame_size;
    logic [WordW-1:0] payload_index;
    logic [ByteW-1:0] payload_byte;
    status_e          status;
  } result_t;

  // reflected crc-32, one byte, eight shift steps
  function automatic logic [WordW-1:0] crc32_byte(input logic [WordW-1:0] crc,
                                                  input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-ByteW){1'b0}}, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/sync_header_payload_crc_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_header_payload_crc_deframer
// Sync-word hunt, header parse, payload pass-through and crc-32 trailer check.
// ----------------------------------------------------------------------------
// an accepted byte's result is registered in the output register
// throughput: one byte per cycle unless the output stalls, set by the crc update
// and the output register, which takes a new result as the old one is read out
// reset: frame state returns to sync hunt, crc to all ones, status_cmd to 0
// and max_payload to 65536; the output register comes up empty
module sync_header_payload_crc_deframer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [shpcd_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [shpcd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [shpcd_pkg::ByteW-1:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] status, [10:3] payload_byte, [42:11] payload_index,
  // [74:43] frame_size, [79:75] zero
  output logic [shpcd_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic                                 m_axis_tuser    // [0] payload_valid
);
  import shpcd_pkg::*;

  logic [ByteW-1:0]   status_cmd_q;
  logic [WordW-1:0]   max_payload_q;

  phase_e             phase_q, phase_d;
  logic [WordW-1:0]   sync_window_q, sync_window_d;
  logic [HdrCntW-1:0] header_count_q, header_count_d;
  logic [HdrShW-1:0]  header_shift_q, header_shift_d;
  logic [WordW-1:0]   frame_length_q, frame_length_d;
  logic [WordW-1:0]   byte_count_q, byte_count_d;
  logic [WordW-1:0]   crc_running_q, crc_running_d;
  logic [WordW-1:0]   crc_received_q, crc_received_d;
  logic [1:0]         crc_count_q, crc_count_d;

  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               pvalid_q, pvalid_d;

  logic               in_fire;
  logic [ByteW-1:0]   b;
  logic [WordW-1:0]   win;
  logic [HdrCntW-1:0] hc_inc;
  logic [ByteW-1:0]   hdr_cmd;
  logic [WordW-1:0]   hdr_len;
  logic [WordW-1:0]   rx_word;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;

  assign win     = {sync_window_q[WordW-ByteW-1:0], b};
  assign hc_inc  = header_count_q + 3'd1;
  assign hdr_cmd = header_shift_q[ByteW-1:0];
  assign hdr_len = header_shift_q[HdrShW-1:ByteW];
  assign rx_word = crc_received_q | ({{(WordW-ByteW){1'b0}}, b} << {crc_count_q, 3'b000});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_cmd_q  <= StatusCmdRst;
      max_payload_q <= MaxPayloadRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_STATUS_CMD) begin
        status_cmd_q <= cfg_data_i[ByteW-1:0];
      end else if (cfg_idx_i == CFG_MAX_PAYLOAD) begin
        max_payload_q <= cfg_data_i[WordW-1:0];
      end
    end
  end

  always_comb begin
    phase_d        = phase_q;
    sync_window_d  = sync_window_q;
    header_count_d = header_count_q;
    header_shift_d = header_shift_q;
    frame_length_d = frame_length_q;
    byte_count_d   = byte_count_q;
    crc_running_d  = crc_running_q;
    crc_received_d = crc_received_q;
    crc_count_d    = crc_count_q;

    res_d.status        = ST_RECEIVING;
    res_d.payload_byte  = '0;
    res_d.payload_index = '0;
    res_d.frame_size    = '0;
    pvalid_d            = 1'b0;

    unique case (phase_q)
      PH_IDLE: begin
        if (win == SyncWord) begin
          sync_window_d  = '0;
          header_count_d = '0;
          header_shift_d = '0;
          phase_d        = PH_HEADER;
        end else begin
          sync_window_d = win;
          res_d.status  = ST_IDLE;
        end
      end
      PH_HEADER: begin
        if (header_count_q < HdrKeptBytes) begin
          header_shift_d = {b, header_shift_q[HdrShW-1:ByteW]};
        end
        header_count_d = hc_inc;
        // last header byte is ignored, the kept five are already in place
        if (hc_inc == HdrBytes) begin
          header_count_d = '0;
          if (hdr_cmd == status_cmd_q) begin
            phase_d      = PH_IDLE;
            res_d.status = ST_STATUS;
          end else if (hdr_len == '0 || hdr_len > max_payload_q) begin
            phase_d      = PH_IDLE;
            res_d.status = ST_SIZE_ERR;
          end else begin
            frame_length_d = hdr_len;
            byte_count_d   = '0;
            crc_running_d  = CrcInit;
            phase_d        = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        pvalid_d            = 1'b1;
        res_d.payload_byte  = b;
        res_d.payload_index = byte_count_q;
        crc_running_d       = crc32_byte(crc_running_q, b);
        byte_count_d        = byte_count_q + 32'd1;
        if (byte_count_d == frame_length_q) begin
          crc_received_d = '0;
          crc_count_d    = '0;
          phase_d        = PH_TRAILER;
        end
      end
      PH_TRAILER: begin
        crc_received_d = rx_word;
        if (crc_count_q == 2'd3) begin
          crc_count_d = '0;
          phase_d     = PH_IDLE;
          if (rx_word != ~crc_running_q) begin
            res_d.status = ST_CRC_ERR;
          end else begin
            res_d.status     = ST_COMPLETE;
            res_d.frame_size = frame_length_q;
          end
        end else begin
          crc_count_d = crc_count_q + 2'd1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      sync_window_q  <= '0;
      header_count_q <= '0;
      header_shift_q <= '0;
      frame_length_q <= '0;
      byte_count_q   <= '0;
      crc_running_q  <= CrcInit;
      crc_received_q <= '0;
      crc_count_q    <= '0;
    end else if (in_fire) begin
      phase_q        <= phase_d;
      sync_window_q  <= sync_window_d;
      header_count_q <= header_count_d;
      header_shift_q <= header_shift_d;
      frame_length_q <= frame_length_d;
      byte_count_q   <= byte_count_d;
      crc_running_q  <= crc_running_d;
      crc_received_q <= crc_received_d;
      crc_count_q    <= crc_count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q    <= res_d;
      pvalid_q <= pvalid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-$bits(result_t)){1'b0}}, res_q};
  assign m_axis_tuser  = pvalid_q;

  a_payload_is_receiving : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pvalid_q |-> res_q.status == ST_RECEIVING)
    else $error("payload result with non-receiving status");

  a_size_only_on_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_size != '0 |-> res_q.status == ST_COMPLETE)
    else $error("frame size reported without completion");

  a_payload_len_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> frame_length_q != '0 && byte_count_q < frame_length_q)
    else $error("payload phase with bad length or count");

  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result register is held");

endmodule
